// File: rtl/dpc_pkg.sv
// Shared constants for the detent position controller: field widths,
// register map and register reset values. No dependencies.
package dpc_pkg;

  // Default encoder position width.
  localparam int DPC_POS_BITS = 24;

  // Configuration field widths.
  localparam int STEP_W = 10;
  localparam int BAND_W = 12;
  localparam int FSE_W  = 16;
  localparam int DRV_W  = 8;
  localparam int CNT_W  = 16;

  // APB register map: register i at byte address 4*i.
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_STEP = 3'd0,
    REG_BAND = 3'd1,
    REG_FSE  = 3'd2,
    REG_MIN  = 3'd3,
    REG_MAX  = 3'd4
  } reg_idx_t;

  // Register reset values.
  localparam logic [STEP_W-1:0] STEP_RST = 10'd50;
  localparam logic [BAND_W-1:0] BAND_RST = 12'd10;
  localparam logic [FSE_W-1:0]  FSE_RST  = 16'd1000;
  localparam logic [DRV_W-1:0]  MIN_RST  = 8'd80;
  localparam logic [DRV_W-1:0]  MAX_RST  = 8'd255;

  // Drive ramp divider: dividend is error (FSE_W) times drive span (DRV_W).
  localparam int DVD_W     = FSE_W + DRV_W;
  localparam int DIV_CNT_W = $clog2(DVD_W);

endpackage

// File: rtl/dpc_if.sv
// Valid/ready channel interfaces for the detent position controller.
// Depends on dpc_pkg for the default position width and field widths.
interface dpc_in_if
  import dpc_pkg::*;
#(
  parameter int POS_BITS = DPC_POS_BITS
) ();
  logic                       valid;
  logic                       ready;
  logic signed [POS_BITS-1:0] encoder_count;
  logic                       turn_event;
  logic                       turn_up;
  logic                       far_clear;
  logic                       near_clear;

  modport source (
    output valid, encoder_count, turn_event, turn_up, far_clear, near_clear,
    input  ready
  );
  modport sink (
    input  valid, encoder_count, turn_event, turn_up, far_clear, near_clear,
    output ready
  );
endinterface

interface dpc_out_if
  import dpc_pkg::*;
#(
  parameter int POS_BITS = DPC_POS_BITS
) ();
  logic                       valid;
  logic                       ready;
  logic [DRV_W-1:0]           drive_cw;
  logic [DRV_W-1:0]           drive_ccw;
  logic                       moving;
  logic signed [POS_BITS-1:0] target_now;
  logic signed [CNT_W-1:0]    detents_now;

  modport source (
    output valid, drive_cw, drive_ccw, moving, target_now, detents_now,
    input  ready
  );
  modport sink (
    input  valid, drive_cw, drive_ccw, moving, target_now, detents_now,
    output ready
  );
endinterface

// File: rtl/detent_position_controller.sv
// Detent position controller top level: sequencer, serial divider,
// move state and APB register file. Depends on dpc_pkg and dpc_if.
//
// Usage:
//   in_ch  : one transfer per control tick (encoder position, detent event
//            and direction, two limit-switch levels).
//   out_ch : one transfer per tick with both drive duties, the move flag,
//            the current target and the detent count.
//   APB    : five registers at byte addresses 0,4,8,12,16; the user writes
//            them only while the block is idle, not enforced by the block;
//            pready is always high, reads return the value.
// Sequence: from the input transfer through TMUL and TADD (target update, skipped
//   when the updated detent count is zero), ERR, MUL, DIV (one-bit-per-cycle
//   restoring divider) and LVL to FIN; MUL, DIV and LVL are skipped when the
//   drive is zero or saturated. in_ch.ready is high only while the sequencer is idle.
// The result sits in an output register, so the next tick is taken while it
//   waits; if the receiver stalls, the sequencer holds the finished tick
//   until the output register frees up.
// Reset (rst, synchronous) clears the move, target, base and detent count and
//   loads the register defaults; no clearing pass is needed.
module detent_position_controller
  import dpc_pkg::*;
#(
  parameter int POS_BITS = DPC_POS_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  dpc_in_if.sink                in_ch,
  dpc_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int PROD_W = STEP_W + 1 + CNT_W;
  localparam int SUM_W  = ((POS_BITS > PROD_W) ? POS_BITS : PROD_W) + 1;
  localparam int ERR_W  = POS_BITS + 1;

  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-POS_BITS+1){1'b0}}, {(POS_BITS-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W-POS_BITS+1){1'b1}}, {(POS_BITS-1){1'b0}}};

  localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
  localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_TMUL = 8'b0000_0010,
    S_TADD = 8'b0000_0100,
    S_ERR  = 8'b0000_1000,
    S_MUL  = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_LVL  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  state_t state;

  // Configuration registers
  logic [STEP_W-1:0] cfg_step;
  logic [BAND_W-1:0] cfg_band;
  logic [FSE_W-1:0]  cfg_fse;
  logic [DRV_W-1:0]  cfg_min;
  logic [DRV_W-1:0]  cfg_max;

  // Move state
  logic                       move_active;
  logic signed [POS_BITS-1:0] target_pos;
  logic signed [POS_BITS-1:0] base_pos;
  logic signed [CNT_W-1:0]    detent_total;

  // Tick working registers
  logic signed [POS_BITS-1:0] pos_r;
  logic                       far_r;
  logic                       near_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic [FSE_W-1:0]           mag_r;
  logic                       drive_ccw_sel;
  logic                       drive_en;
  logic [DRV_W-1:0]           drive_lvl;
  logic                       neg_r;
  logic [DVD_W-1:0]           dvd_r;
  logic [FSE_W-1:0]           rem_r;
  logic [DIV_CNT_W-1:0]       bit_cnt;

  // Output register
  logic                       out_valid;
  logic [DRV_W-1:0]           out_cw;
  logic [DRV_W-1:0]           out_ccw;
  logic                       out_moving;
  logic signed [POS_BITS-1:0] out_target;
  logic signed [CNT_W-1:0]    out_detents;

  logic in_xfer;
  logic out_load;
  logic cfg_wr;

  assign in_ch.ready = (state == S_IDLE);
  assign in_xfer     = in_ch.valid && (state == S_IDLE);
  assign out_load    = (state == S_FIN) && (!out_valid || out_ch.ready);
  assign cfg_wr      = psel && penable && pwrite;
  assign pready      = 1'b1;

  // Detent count update on the incoming tick
  logic signed [CNT_W-1:0] tot_next;
  always_comb begin
    tot_next = detent_total;
    if (in_ch.turn_event) begin
      if (in_ch.turn_up) begin
        if (detent_total != CNT_MIN) tot_next = detent_total - CNT_W'(1);
      end else begin
        if (detent_total != CNT_MAX) tot_next = detent_total + CNT_W'(1);
      end
    end
  end

  // Target sum with saturation
  logic signed [SUM_W-1:0] tgt_sum;
  assign tgt_sum = $signed({{(SUM_W-POS_BITS){base_pos[POS_BITS-1]}}, base_pos})
                 + $signed({{(SUM_W-PROD_W){prod_r[PROD_W-1]}}, prod_r});

  // Error against the updated target and direction decision
  logic signed [ERR_W-1:0] err;
  logic signed [ERR_W-1:0] nerr;
  logic signed [ERR_W-1:0] band_x;
  logic        [ERR_W-1:0] mag_x;
  logic                    go_ccw;
  logic                    go_cw;
  assign err    = $signed({target_pos[POS_BITS-1], target_pos})
                - $signed({pos_r[POS_BITS-1], pos_r});
  assign nerr   = -err;
  assign band_x = $signed({{(ERR_W-BAND_W){1'b0}}, cfg_band});
  assign go_ccw = (err > band_x) && far_r;
  assign go_cw  = !go_ccw && (nerr > band_x) && near_r;
  assign mag_x  = go_ccw ? err : nerr;

  // Drive span, sign kept apart
  logic             span_neg;
  logic [DRV_W-1:0] span_abs;
  assign span_neg = cfg_max < cfg_min;
  assign span_abs = span_neg ? (cfg_min - cfg_max) : (cfg_max - cfg_min);

  // Restoring divider step: one quotient bit per cycle
  logic [FSE_W:0] div_sh;
  logic [FSE_W:0] div_diff;
  logic           div_q;
  assign div_sh   = {rem_r, dvd_r[DVD_W-1]};
  assign div_diff = div_sh - {1'b0, cfg_fse};
  assign div_q    = div_sh >= {1'b0, cfg_fse};

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      move_active  <= 1'b0;
      target_pos   <= '0;
      base_pos     <= '0;
      detent_total <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            pos_r        <= in_ch.encoder_count;
            far_r        <= in_ch.far_clear;
            near_r       <= in_ch.near_clear;
            detent_total <= tot_next;
            if (tot_next != '0) begin
              if (!move_active) begin
                base_pos    <= in_ch.encoder_count;
                move_active <= 1'b1;
              end
              state <= S_TMUL;
            end else begin
              state <= S_ERR;
            end
          end
        end
        S_TMUL: begin
          prod_r <= $signed({1'b0, cfg_step}) * detent_total;
          state  <= S_TADD;
        end
        S_TADD: begin
          if (tgt_sum > SAT_HI) begin
            target_pos <= SAT_HI[POS_BITS-1:0];
          end else if (tgt_sum < SAT_LO) begin
            target_pos <= SAT_LO[POS_BITS-1:0];
          end else begin
            target_pos <= tgt_sum[POS_BITS-1:0];
          end
          state <= S_ERR;
        end
        S_ERR: begin
          drive_ccw_sel <= go_ccw;
          drive_lvl     <= '0;
          if (!move_active) begin
            drive_en <= 1'b0;
            state    <= S_FIN;
          end else if (!go_ccw && !go_cw) begin
            // within the dead band or blocked by a switch: end the move
            move_active  <= 1'b0;
            detent_total <= '0;
            drive_en     <= 1'b0;
            state        <= S_FIN;
          end else begin
            drive_en <= 1'b1;
            if (mag_x >= {{(ERR_W-FSE_W){1'b0}}, cfg_fse}) begin
              drive_lvl <= cfg_max;
              state     <= S_FIN;
            end else begin
              mag_r <= mag_x[FSE_W-1:0];
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          dvd_r   <= mag_r * span_abs;
          neg_r   <= span_neg;
          rem_r   <= '0;
          bit_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          rem_r   <= div_q ? div_diff[FSE_W-1:0] : div_sh[FSE_W-1:0];
          dvd_r   <= {dvd_r[DVD_W-2:0], div_q};
          bit_cnt <= bit_cnt + DIV_CNT_W'(1);
          if (bit_cnt == DIV_CNT_W'(DVD_W-1)) state <= S_LVL;
        end
        S_LVL: begin
          // quotient stays below the span, so it fits the drive width
          drive_lvl <= neg_r ? (cfg_min - dvd_r[DRV_W-1:0])
                             : (cfg_min + dvd_r[DRV_W-1:0]);
          state     <= S_FIN;
        end
        S_FIN: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cw      <= (drive_en && !drive_ccw_sel) ? drive_lvl : '0;
      out_ccw     <= (drive_en && drive_ccw_sel) ? drive_lvl : '0;
      out_moving  <= move_active;
      out_target  <= target_pos;
      out_detents <= detent_total;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.drive_cw    = out_cw;
  assign out_ch.drive_ccw   = out_ccw;
  assign out_ch.moving      = out_moving;
  assign out_ch.target_now  = out_target;
  assign out_ch.detents_now = out_detents;

  // APB register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_step <= STEP_RST;
      cfg_band <= BAND_RST;
      cfg_fse  <= FSE_RST;
      cfg_min  <= MIN_RST;
      cfg_max  <= MAX_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_STEP: cfg_step <= pwdata[STEP_W-1:0];
        REG_BAND: cfg_band <= pwdata[BAND_W-1:0];
        REG_FSE:  cfg_fse  <= pwdata[FSE_W-1:0];
        REG_MIN:  cfg_min  <= pwdata[DRV_W-1:0];
        REG_MAX:  cfg_max  <= pwdata[DRV_W-1:0];
        default: ;
      endcase
    end
  end

  // APB read mux
  always_comb begin
    unique case (paddr[4:2])
      REG_STEP: prdata = {{(APB_DATA_W-STEP_W){1'b0}}, cfg_step};
      REG_BAND: prdata = {{(APB_DATA_W-BAND_W){1'b0}}, cfg_band};
      REG_FSE:  prdata = {{(APB_DATA_W-FSE_W){1'b0}}, cfg_fse};
      REG_MIN:  prdata = {{(APB_DATA_W-DRV_W){1'b0}}, cfg_min};
      REG_MAX:  prdata = {{(APB_DATA_W-DRV_W){1'b0}}, cfg_max};
      default:  prdata = '0;
    endcase
  end

endmodule
